### design/eff_pkg.sv
// Shared types, constants and single-precision arithmetic functions for the Euler flux block.
`timescale 1ns / 1ps
package eff_pkg;

  typedef logic [31:0] fp_t;

  typedef struct packed {
    logic signed [10:0] e;
    logic [23:0]        m;
  } nrm_t;

  // Item state carried along the main pipeline
  typedef struct packed {
    logic [1:0]       dir;
    fp_t              n;
    fp_t              t1;
    fp_t              t2;
    fp_t              e;
    logic [3:0][31:0] sc;
    fp_t              a;
    fp_t              b;
    fp_t              c;
    fp_t              s;
    fp_t              h;
    fp_t              vn;
    fp_t              p;
    fp_t              fn;
    fp_t              ft1;
    fp_t              ft2;
    fp_t              q;
    fp_t              fe;
    logic [3:0][31:0] sf;
  } it_t;

  localparam fp_t CANON_NAN   = 32'h7FC0_0000;
  localparam fp_t FP_HALF     = 32'h3F00_0000;
  localparam fp_t GAMMA_RESET = 32'h3F2A_AAAB;
  localparam fp_t FLOOR_RESET = 32'h0000_0000;

  localparam logic [1:0] DIR_X    = 2'd0;
  localparam logic [1:0] DIR_Y    = 2'd1;
  localparam logic [1:0] DIR_Z    = 2'd2;
  localparam logic [1:0] DIR_XALT = 2'd3;

  localparam logic REG_GAMMA = 1'b0;
  localparam logic REG_FLOOR = 1'b1;

  localparam int RECIP_STEPS = 13;
  localparam int RECIP_BITS  = 2;
  localparam int RECIP_LAT   = RECIP_STEPS + 2;
  localparam int POST_STAGES = 7;
  localparam int TOTAL       = RECIP_LAT + POST_STAGES;

  function automatic logic fp_is_nan(fp_t x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic fp_is_inf(fp_t x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic fp_is_zero(fp_t x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic fp_t fp_canon(fp_t x);
    return fp_is_nan(x) ? CANON_NAN : x;
  endfunction

  // Normalise a finite non-zero operand: hidden one at bit 23
  function automatic nrm_t fp_norm(fp_t x);
    nrm_t       r;
    logic [4:0] k;
    k = 5'd0;
    if (x[30:23] != 8'd0) begin
      r.m = {1'b1, x[22:0]};
      r.e = $signed({3'b0, x[30:23]});
    end else begin
      for (int i = 0; i < 23; i++) begin
        if (x[i]) k = 5'(i);
      end
      r.m = {1'b0, x[22:0]} << (5'd23 - k);
      r.e = $signed({6'b0, k}) - 11'sd22;
    end
    return r;
  endfunction

  // Round to nearest even; m[25] leading one, m[1] guard, m[0] sticky
  function automatic fp_t fp_round(logic s, logic signed [10:0] e, logic [25:0] m);
    logic [25:0]        mm;
    logic [7:0]         expf;
    logic signed [10:0] amt;
    logic [4:0]         sh;
    logic               inc;
    logic [30:0]        mag;
    fp_t                res;
    mm   = m;
    expf = 8'd0;
    amt  = 11'sd0;
    sh   = 5'd0;
    if (e >= 11'sd255) begin
      res = {s, 8'hFF, 23'd0};
    end else begin
      if (e >= 11'sd1) begin
        mm   = m;
        expf = e[7:0];
      end else begin
        amt  = 11'sd1 - e;
        sh   = (amt > 11'sd26) ? 5'd26 : amt[4:0];
        mm   = (m >> sh) | {25'd0, |(m & ((26'd1 << sh) - 26'd1))};
        expf = 8'd0;
      end
      inc = mm[1] & (mm[0] | mm[2]);
      mag = {expf, mm[24:2]} + {30'd0, inc};
      res = {s, mag};
    end
    return res;
  endfunction

  function automatic fp_t fp_mul(fp_t a, fp_t b);
    logic               s;
    nrm_t               na;
    nrm_t               nb;
    logic [47:0]        p;
    logic signed [10:0] e;
    logic [25:0]        m;
    fp_t                res;
    s  = a[31] ^ b[31];
    na = '0;
    nb = '0;
    if (fp_is_nan(a) || fp_is_nan(b) || (fp_is_inf(a) && fp_is_zero(b)) ||
        (fp_is_zero(a) && fp_is_inf(b))) begin
      res = CANON_NAN;
    end else if (fp_is_inf(a) || fp_is_inf(b)) begin
      res = {s, 8'hFF, 23'd0};
    end else if (fp_is_zero(a) || fp_is_zero(b)) begin
      res = {s, 31'd0};
    end else begin
      na = fp_norm(a);
      nb = fp_norm(b);
      p  = na.m * nb.m;
      e  = na.e + nb.e - 11'sd127;
      if (p[47]) begin
        m = {p[47:23], |p[22:0]};
        e = e + 11'sd1;
      end else begin
        m = {p[46:22], |p[21:0]};
      end
      res = fp_round(s, e, m);
    end
    return res;
  endfunction

  function automatic fp_t fp_add(fp_t a, fp_t b);
    fp_t                x;
    fp_t                y;
    logic [7:0]         ex;
    logic [7:0]         ey;
    logic [7:0]         d;
    logic [26:0]        ma;
    logic [26:0]        mb0;
    logic [26:0]        mb;
    logic [27:0]        sum;
    logic [4:0]         ld;
    logic [1:0]         sh;
    logic signed [10:0] e;
    logic [25:0]        m;
    fp_t                res;
    x   = a;
    y   = b;
    ld  = 5'd0;
    mb  = '0;
    sum = '0;
    if (fp_is_nan(a) || fp_is_nan(b)) begin
      res = CANON_NAN;
    end else if (fp_is_inf(a) && fp_is_inf(b)) begin
      res = (a[31] == b[31]) ? a : CANON_NAN;
    end else if (fp_is_inf(a)) begin
      res = a;
    end else if (fp_is_inf(b)) begin
      res = b;
    end else if (fp_is_zero(a) && fp_is_zero(b)) begin
      res = {a[31] & b[31], 31'd0};
    end else begin
      if (b[30:0] > a[30:0]) begin
        x = b;
        y = a;
      end
      ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      ma  = {x[30:23] != 8'd0, x[22:0], 3'b000};
      mb0 = {y[30:23] != 8'd0, y[22:0], 3'b000};
      d   = ex - ey;
      if (d >= 8'd27) begin
        mb = {26'd0, |mb0};
      end else begin
        mb = (mb0 >> d[4:0]) | {26'd0, |(mb0 & ((27'd1 << d[4:0]) - 27'd1))};
      end
      if (x[31] ^ y[31]) begin
        sum = {1'b0, ma} - {1'b0, mb};
      end else begin
        sum = {1'b0, ma} + {1'b0, mb};
      end
      if (sum == 28'd0) begin
        res = 32'd0;
      end else begin
        for (int i = 0; i < 28; i++) begin
          if (sum[i]) ld = 5'(i);
        end
        e = $signed({3'b0, ex}) + $signed({6'b0, ld}) - 11'sd26;
        if (ld >= 5'd25) begin
          sh = 2'(ld - 5'd25);
          m  = 26'(sum >> sh) | {25'd0, |(sum & ((28'd1 << sh) - 28'd1))};
        end else begin
          m  = 26'(sum << (5'd25 - ld));
        end
        res = fp_round(x[31], e, m);
      end
    end
    return res;
  endfunction

  // Ordered greater-than; false when either side is NaN
  function automatic logic fp_gt(fp_t a, fp_t b);
    logic r;
    if (fp_is_nan(a) || fp_is_nan(b)) begin
      r = 1'b0;
    end else if (fp_is_zero(a) && fp_is_zero(b)) begin
      r = 1'b0;
    end else if (a[31] != b[31]) begin
      r = !a[31];
    end else if (!a[31]) begin
      r = a[30:0] > b[30:0];
    end else begin
      r = a[30:0] < b[30:0];
    end
    return r;
  endfunction

  function automatic fp_t fp_floor(fp_t p, fp_t lo);
    return (fp_gt(p, lo) || fp_is_nan(lo)) ? p : lo;
  endfunction

endpackage

### design/euler_flux_from_conserved.sv
// Top level of the ideal-gas Euler flux pipeline with its configuration registers.
`timescale 1ns / 1ps
// Ideal-gas Euler flux from one cell's conserved state, IEEE single throughout with
// round to nearest even and subnormals, each operation rounded on its own. One cell
// enters per clock while the output side does not stall. The pipeline is the pipelined
// reciprocal of the density (15 stages: unpack, 13 stages of two quotient bits each,
// round), followed by seven stages of single multiplies, adds and the pressure floor.
// Stalling the output holds the whole pipeline; nothing is dropped or repeated.
// Direction 3 behaves as x. NaN results leave as the quiet NaN 0x7FC00000. Write
// gamma_minus_one and pressure_floor only while the pipeline is empty.
module euler_flux_from_conserved (
  input  logic         clk,
  input  logic         rst,
  // tdata: density, momentum_x, momentum_y, momentum_z, total_energy,
  //        scalar_a, scalar_b, scalar_c, scalar_d (32 bits each, lowest first)
  input  logic [287:0] s_tdata,
  // tuser: direction
  input  logic [1:0]   s_tuser,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: mass_flux, xmom_flux, ymom_flux, zmom_flux, energy_flux,
  //        scalar_a_flux, scalar_b_flux, scalar_c_flux, scalar_d_flux (lowest first)
  output logic [287:0] m_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);
  import eff_pkg::*;

  localparam int S_SQR  = 1;
  localparam int S_SAB  = 2;
  localparam int S_SUM  = 3;
  localparam int S_VN   = RECIP_LAT;
  localparam int S_PROD = RECIP_LAT + 1;
  localparam int S_DIFF = RECIP_LAT + 2;
  localparam int S_GAM  = RECIP_LAT + 3;
  localparam int S_FLR  = RECIP_LAT + 4;
  localparam int S_FN   = RECIP_LAT + 5;
  localparam int S_FE   = RECIP_LAT + 6;

  fp_t              gamma;
  fp_t              pfloor;
  fp_t              recip;
  logic             en;
  logic [TOTAL-1:0] v;
  it_t              pl [TOTAL];
  it_t              last;
  fp_t              fx;
  fp_t              fy;
  fp_t              fz;

  // Always ready; the user must change the registers only while the pipeline is empty
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma  <= GAMMA_RESET;
      pfloor <= FLOOR_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAMMA: gamma  <= cfg_data;
        REG_FLOOR: pfloor <= cfg_data;
      endcase
    end
  end

  // One enable for every stage: advance when the output slot is empty or taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[TOTAL-2:0], s_tvalid};
    end
  end

  eff_recip u_recip (
    .clk (clk),
    .en  (en),
    .d   (s_tdata[31:0]),
    .r   (recip)
  );

  for (genvar k = 0; k < TOTAL; k++) begin : g_st
    it_t nx;
    if (k == 0) begin : g_in
      // Rotate the momenta so that the flux axis comes first
      always_comb begin
        nx       = '0;
        nx.dir   = s_tuser;
        nx.e     = s_tdata[159:128];
        nx.sc[0] = s_tdata[191:160];
        nx.sc[1] = s_tdata[223:192];
        nx.sc[2] = s_tdata[255:224];
        nx.sc[3] = s_tdata[287:256];
        unique case (s_tuser)
          DIR_Y: begin
            nx.n  = s_tdata[95:64];
            nx.t1 = s_tdata[127:96];
            nx.t2 = s_tdata[63:32];
          end
          DIR_Z: begin
            nx.n  = s_tdata[127:96];
            nx.t1 = s_tdata[63:32];
            nx.t2 = s_tdata[95:64];
          end
          DIR_X, DIR_XALT: begin
            nx.n  = s_tdata[63:32];
            nx.t1 = s_tdata[95:64];
            nx.t2 = s_tdata[127:96];
          end
        endcase
      end
    end else begin : g_op
      always_comb begin
        nx = pl[k-1];
        if (k == S_SQR) begin
          nx.a = fp_mul(pl[k-1].n, pl[k-1].n);
          nx.b = fp_mul(pl[k-1].t1, pl[k-1].t1);
          nx.c = fp_mul(pl[k-1].t2, pl[k-1].t2);
        end
        if (k == S_SAB) begin
          nx.s = fp_add(pl[k-1].a, pl[k-1].b);
        end
        if (k == S_SUM) begin
          nx.s = fp_add(pl[k-1].s, pl[k-1].c);
        end
        // Reciprocal of the density arrives here
        if (k == S_VN) begin
          nx.h  = fp_mul(FP_HALF, recip);
          nx.vn = fp_mul(recip, pl[k-1].n);
        end
        if (k == S_PROD) begin
          nx.h   = fp_mul(pl[k-1].h, pl[k-1].s);
          nx.fn  = fp_mul(pl[k-1].vn, pl[k-1].n);
          nx.ft1 = fp_mul(pl[k-1].vn, pl[k-1].t1);
          nx.ft2 = fp_mul(pl[k-1].vn, pl[k-1].t2);
          for (int j = 0; j < 4; j++) begin
            nx.sf[j] = fp_mul(pl[k-1].sc[j], pl[k-1].vn);
          end
        end
        if (k == S_DIFF) begin
          nx.p = fp_add(pl[k-1].e, {~pl[k-1].h[31], pl[k-1].h[30:0]});
        end
        if (k == S_GAM) begin
          nx.p = fp_mul(pl[k-1].p, gamma);
        end
        if (k == S_FLR) begin
          nx.p = fp_floor(pl[k-1].p, pfloor);
        end
        if (k == S_FN) begin
          nx.fn = fp_add(pl[k-1].fn, pl[k-1].p);
          nx.q  = fp_add(pl[k-1].e, pl[k-1].p);
        end
        if (k == S_FE) begin
          nx.fe = fp_mul(pl[k-1].vn, pl[k-1].q);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pl[k] <= nx;
      end
    end
  end

  // Rotate the momentum fluxes back to x, y, z order and canonicalise NaNs
  assign last = pl[TOTAL-1];

  always_comb begin
    unique case (last.dir)
      DIR_Y: begin
        fx = last.ft2;
        fy = last.fn;
        fz = last.ft1;
      end
      DIR_Z: begin
        fx = last.ft1;
        fy = last.ft2;
        fz = last.fn;
      end
      DIR_X, DIR_XALT: begin
        fx = last.fn;
        fy = last.ft1;
        fz = last.ft2;
      end
    endcase
  end

  assign m_tvalid = v[TOTAL-1];
  assign m_tdata  = {fp_canon(last.sf[3]), fp_canon(last.sf[2]), fp_canon(last.sf[1]),
                     fp_canon(last.sf[0]), fp_canon(last.fe), fp_canon(fz),
                     fp_canon(fy), fp_canon(fx), fp_canon(last.n)};

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(v))
    else $error("pipeline valid bits moved during a stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered straight after reset");

  a_mass_nan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[30:23] == 8'hFF && m_tdata[22:0] != 23'd0
      |-> m_tdata[31:0] == CANON_NAN)
    else $error("mass flux NaN not canonical");

  a_energy_nan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[158:151] == 8'hFF && m_tdata[150:128] != 23'd0
      |-> m_tdata[159:128] == CANON_NAN)
    else $error("energy flux NaN not canonical");

endmodule

### design/eff_recip.sv
// Pipelined correctly rounded single-precision reciprocal, two quotient bits per stage.
`timescale 1ns / 1ps
module eff_recip (
  input  logic         clk,
  input  logic         en,
  input  eff_pkg::fp_t d,
  output eff_pkg::fp_t r
);
  import eff_pkg::*;

  typedef struct packed {
    logic               spec;
    fp_t                sv;
    logic               s;
    logic               p2;
    logic signed [10:0] e;
    logic [23:0]        md;
    logic [25:0]        rem;
    logic [25:0]        q;
  } rcp_t;

  rcp_t st [RECIP_STEPS + 1];
  rcp_t st0_next;
  nrm_t nd;

  // Unpack: catch specials, normalise the divisor
  always_comb begin
    st0_next      = '0;
    st0_next.s    = d[31];
    st0_next.rem  = 26'h100_0000;
    nd            = fp_norm(d);
    if (fp_is_nan(d)) begin
      st0_next.spec = 1'b1;
      st0_next.sv   = CANON_NAN;
    end else if (fp_is_zero(d)) begin
      st0_next.spec = 1'b1;
      st0_next.sv   = {d[31], 8'hFF, 23'd0};
    end else if (fp_is_inf(d)) begin
      st0_next.spec = 1'b1;
      st0_next.sv   = {d[31], 31'd0};
    end else begin
      st0_next.md = nd.m;
      st0_next.p2 = (nd.m == 24'h80_0000);
      st0_next.e  = st0_next.p2 ? (11'sd254 - nd.e) : (11'sd253 - nd.e);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= st0_next;
    end
  end

  for (genvar k = 1; k <= RECIP_STEPS; k++) begin : g_div
    rcp_t nx;
    always_comb begin
      nx = st[k-1];
      for (int j = 0; j < RECIP_BITS; j++) begin
        if (nx.rem >= {2'b0, nx.md}) begin
          nx.q   = {nx.q[24:0], 1'b1};
          nx.rem = (nx.rem - {2'b0, nx.md}) << 1;
        end else begin
          nx.q   = {nx.q[24:0], 1'b0};
          nx.rem = nx.rem << 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= nx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (st[RECIP_STEPS].spec) begin
        r <= st[RECIP_STEPS].sv;
      end else if (st[RECIP_STEPS].p2) begin
        r <= fp_round(st[RECIP_STEPS].s, st[RECIP_STEPS].e, 26'h200_0000);
      end else begin
        r <= fp_round(st[RECIP_STEPS].s, st[RECIP_STEPS].e,
                      {st[RECIP_STEPS].q[25:1],
                       st[RECIP_STEPS].q[0] | (st[RECIP_STEPS].rem != 26'd0)});
      end
    end
  end

endmodule
